@@ design/vpfa_pkg.sv @@
`default_nettype none
package vpfa_pkg;

	localparam int SZ_W      = 16;
	localparam int ID_W      = 8;
	localparam int RUN_W     = 16;
	localparam int INST_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_MAX_SEGMENTS  = 32;
	localparam int DEF_PENDING_DEPTH = 16;

	localparam logic [SZ_W-1:0] TOTAL_RST = 16'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIT   = 1'b1;

	localparam logic [1:0] ST_PLACED     = 2'd0;
	localparam logic [1:0] ST_QUEUED     = 2'd1;
	localparam logic [1:0] ST_DROP_PEND  = 2'd2;
	localparam logic [1:0] ST_DROP_TABLE = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_MAP    = 1'b1;
	localparam logic CMD_ARRIVE  = 1'b0;
	localparam logic CMD_END     = 1'b1;

	typedef struct packed {
		logic             free;
		logic [ID_W-1:0]  owner;
		logic [SZ_W-1:0]  size;
		logic [RUN_W-1:0] remaining;
	} seg_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SZ_W-1:0]  size;
		logic [RUN_W-1:0] run;
	} pend_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
		logic flush;
	} pend_ctrl_t;

endpackage
`default_nettype wire

@@ design/vpfa_seg_mem.sv @@
`default_nettype none
module vpfa_seg_mem
	import vpfa_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            restart,
	input  wire logic [SZ_W-1:0]                 total,
	input  wire logic                            re,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] raddr,
	output seg_entry_t                           rdata,
	input  wire logic                            we,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] waddr,
	input  wire seg_entry_t                      wdata
);

	seg_entry_t mem [MAX_SEGMENTS];
	seg_entry_t mem_q;
	logic       fresh_q;
	logic       hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_q <= mem[raddr];
		end
	end

	// entry 0 reads as one hole of the full size until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			hit_q   <= 1'b0;
		end else begin
			if (restart) begin
				fresh_q <= 1'b1;
			end else if (we && waddr == '0) begin
				fresh_q <= 1'b0;
			end
			if (re) begin
				hit_q <= fresh_q && raddr == '0;
			end
		end
	end

	always_comb begin
		rdata = mem_q;
		if (hit_q) begin
			rdata.free      = 1'b1;
			rdata.owner     = '0;
			rdata.size      = total;
			rdata.remaining = '0;
		end
	end

endmodule
`default_nettype wire

@@ design/vpfa_pend_fifo.sv @@
`default_nettype none
module vpfa_pend_fifo
	import vpfa_pkg::*;
#(
	parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pend_ctrl_t                       ctrl,
	input  wire pend_entry_t                      wdata,
	output pend_entry_t                           rdata,
	output logic [$clog2(PENDING_DEPTH+1)-1:0]    count
);

	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);

	pend_entry_t     mem [PENDING_DEPTH];
	pend_entry_t     rd_q;
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   tail_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wdata;
		end
		if (ctrl.rd) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (ctrl.flush) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= nxt(tail_q);
			end
			if (ctrl.pop) begin
				head_q <= nxt(head_q);
			end
			if (ctrl.push && !ctrl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = rd_q;
	assign count = cnt_q;

endmodule
`default_nettype wire

@@ design/variable_partition_fit_allocator_unit.sv @@
// Variable-partition allocator. Memory is an ordered segment list (holes and owned
// segments) in a synchronous two-port table, plus a FIFO of waiting requests.
// An arrival (cmd 0) is placed best fit or worst fit by fit_mode and answered with one
// status transfer; an end-of-instant item (cmd 1) answers with one map transfer per
// segment, then ages the segments, merges holes and retries the queue first fit.
// Items are taken one at a time; req_stall is high until the block is back in idle.
// A split moves each later segment up one entry, then writes the new hole and owner.
// A queue retry that places its head goes on to the next head; an oversized head is
// dropped, and the retry stops at the first head that does not fit.
// Output stalls hold the status and map transfers.
// A write to total_memory restarts the map, the queue and the instant count.
`default_nettype none
module variable_partition_fit_allocator_unit
	import vpfa_pkg::*;
#(
	parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
	parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 cmd,
	input  wire logic [ID_W-1:0]      proc_id,
	input  wire logic [SZ_W-1:0]      proc_size,
	input  wire logic [RUN_W-1:0]     run_time,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic                      kind,
	output logic [1:0]                status,
	output logic [INST_W-1:0]         instant,
	output logic [SZ_W-1:0]           seg_start,
	output logic [SZ_W-1:0]           seg_size,
	output logic                      seg_is_hole,
	output logic [ID_W-1:0]           seg_owner,
	output logic                      still_active,
	output logic                      last
);

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int PC_W  = $clog2(PENDING_DEPTH + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_PLACE    = 4'd2;
	localparam logic [3:0] S_SHIFT_RD = 4'd3;
	localparam logic [3:0] S_SHIFT_WR = 4'd4;
	localparam logic [3:0] S_WR_HOLE  = 4'd5;
	localparam logic [3:0] S_WR_OWN   = 4'd6;
	localparam logic [3:0] S_ACT_RD   = 4'd7;
	localparam logic [3:0] S_ACT_CHK  = 4'd8;
	localparam logic [3:0] S_ARR_OUT  = 4'd9;
	localparam logic [3:0] S_MAP_RD   = 4'd10;
	localparam logic [3:0] S_MAP_EMIT = 4'd11;
	localparam logic [3:0] S_MAP_END  = 4'd12;
	localparam logic [3:0] S_RETRY    = 4'd13;
	localparam logic [3:0] S_RETRY_HD = 4'd14;

	logic [3:0]       state_q;
	logic [SZ_W-1:0]  total_q;
	logic             fit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [INST_W-1:0] inst_q;
	logic             end_q;
	logic             retry_q;
	logic [ID_W-1:0]  id_q;
	logic [SZ_W-1:0]  size_q;
	logic [RUN_W-1:0] run_q;
	logic [CNT_W-1:0] i_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             have_q;
	logic [IDX_W-1:0] pick_q;
	logic [SZ_W-1:0]  best_q;
	logic [IDX_W-1:0] j_q;
	logic [1:0]       status_q;
	logic             act_q;
	logic [IDX_W-1:0] w_q;
	seg_entry_t       acc_q;
	logic             acc_v_q;
	logic [SZ_W-1:0]  start_q;

	logic             rsp_valid_q;
	logic             kind_q;
	logic [1:0]       rstat_q;
	logic [INST_W-1:0] rinst_q;
	logic [SZ_W-1:0]  rstart_q;
	logic [SZ_W-1:0]  rsize_q;
	logic             rhole_q;
	logic [ID_W-1:0]  rowner_q;
	logic             ract_q;
	logic             rlast_q;

	logic             restart;
	logic             seg_re;
	logic [IDX_W-1:0] seg_raddr;
	seg_entry_t       seg_rdata;
	logic             seg_we;
	logic [IDX_W-1:0] seg_waddr;
	seg_entry_t       seg_wdata;

	pend_ctrl_t       pctrl;
	pend_entry_t      pend_wdata;
	pend_entry_t      pend_rdata;
	logic [PC_W-1:0]  pcnt;

	logic             out_free;
	logic             rsp_load;
	logic             fits;
	logic             better;
	logic [SZ_W-1:0]  diff;
	seg_entry_t       dec;
	logic [SZ_W:0]    sum;
	logic [SZ_W-1:0]  msize;
	logic             merge_now;
	logic             scan_done;
	logic             act_now;
	logic [CNT_W-1:0] cnt_m1;

	vpfa_seg_mem #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(restart),
		.total  (total_q),
		.re     (seg_re),
		.raddr  (seg_raddr),
		.rdata  (seg_rdata),
		.we     (seg_we),
		.waddr  (seg_waddr),
		.wdata  (seg_wdata)
	);

	vpfa_pend_fifo #(
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_pend (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (pctrl),
		.wdata (pend_wdata),
		.rdata (pend_rdata),
		.count (pcnt)
	);

	assign restart   = cfg_we && cfg_index == REG_TOTAL;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = out_free && (state_q == S_ARR_OUT || state_q == S_MAP_EMIT);
	assign scan_done = !(i_q < cnt_q) && !v_s1;
	assign cnt_m1    = cnt_q - 1'b1;

	always_comb begin
		fits   = seg_rdata.free && size_q <= seg_rdata.size;
		diff   = seg_rdata.size - size_q;
		better = !have_q || (!retry_q && (fit_q ? diff > best_q : diff < best_q));

		dec = seg_rdata;
		if (!seg_rdata.free) begin
			if (seg_rdata.remaining != '0) begin
				dec.remaining = seg_rdata.remaining - 1'b1;
			end
			if (dec.remaining == '0) begin
				dec.free  = 1'b1;
				dec.owner = '0;
			end
		end
		sum       = {1'b0, acc_q.size} + {1'b0, dec.size};
		msize     = sum[SZ_W] ? '1 : sum[SZ_W-1:0];
		merge_now = acc_v_q && acc_q.free && dec.free;

		act_now = pcnt != '0 ||
			((cnt_q > CNT_W'(1) || !seg_rdata.free) &&
			 !(seg_rdata.free && seg_rdata.size == total_q));
	end

	always_comb begin
		seg_re     = 1'b0;
		seg_raddr  = '0;
		seg_we     = 1'b0;
		seg_waddr  = '0;
		seg_wdata  = acc_q;
		pctrl      = '0;
		pctrl.flush = restart;
		pend_wdata.id   = id_q;
		pend_wdata.size = size_q;
		pend_wdata.run  = run_q;
		unique case (state_q)
			S_SCAN: begin
				seg_re    = i_q < cnt_q;
				seg_raddr = i_q[IDX_W-1:0];
				pctrl.push = scan_done && !have_q && !retry_q &&
					pcnt < PC_W'(PENDING_DEPTH);
			end
			S_SHIFT_RD: begin
				seg_re    = 1'b1;
				seg_raddr = j_q;
			end
			S_SHIFT_WR: begin
				seg_we    = 1'b1;
				seg_waddr = j_q + 1'b1;
				seg_wdata = seg_rdata;
			end
			S_WR_HOLE: begin
				seg_we              = 1'b1;
				seg_waddr           = pick_q + 1'b1;
				seg_wdata.free      = 1'b1;
				seg_wdata.owner     = '0;
				seg_wdata.size      = best_q;
				seg_wdata.remaining = '0;
			end
			S_WR_OWN: begin
				seg_we              = 1'b1;
				seg_waddr           = pick_q;
				seg_wdata.free      = 1'b0;
				seg_wdata.owner     = id_q;
				seg_wdata.size      = size_q;
				seg_wdata.remaining = run_q;
				pctrl.pop           = retry_q;
			end
			S_ACT_RD: begin
				seg_re = 1'b1;
			end
			S_MAP_RD: begin
				seg_re    = 1'b1;
				seg_raddr = i_q[IDX_W-1:0];
			end
			S_MAP_EMIT: begin
				seg_we    = out_free && acc_v_q && !merge_now;
				seg_waddr = w_q;
			end
			S_MAP_END: begin
				seg_we    = 1'b1;
				seg_waddr = w_q;
			end
			S_RETRY: begin
				pctrl.rd = pcnt != '0;
			end
			S_RETRY_HD: begin
				pctrl.pop = pend_rdata.size > total_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= TOTAL_RST;
			fit_q       <= 1'b0;
			cnt_q       <= CNT_W'(1);
			inst_q      <= INST_W'(1);
			end_q       <= 1'b0;
			retry_q     <= 1'b0;
			id_q        <= '0;
			size_q      <= '0;
			run_q       <= '0;
			i_q         <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			have_q      <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			j_q         <= '0;
			status_q    <= ST_PLACED;
			act_q       <= 1'b0;
			w_q         <= '0;
			acc_q       <= '0;
			acc_v_q     <= 1'b0;
			start_q     <= '0;
			rsp_valid_q <= 1'b0;
			kind_q      <= KIND_STATUS;
			rstat_q     <= ST_PLACED;
			rinst_q     <= '0;
			rstart_q    <= '0;
			rsize_q     <= '0;
			rhole_q     <= 1'b0;
			rowner_q    <= '0;
			ract_q      <= 1'b0;
			rlast_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_TOTAL: begin
						total_q <= cfg_data;
						cnt_q   <= CNT_W'(1);
						inst_q  <= INST_W'(1);
					end
					REG_FIT: begin
						fit_q <= cfg_data[0];
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						id_q    <= proc_id;
						size_q  <= proc_size;
						run_q   <= (run_time == '0) ? RUN_W'(1) : run_time;
						end_q   <= cmd;
						i_q     <= '0;
						v_s1    <= 1'b0;
						have_q  <= 1'b0;
						retry_q <= 1'b0;
						state_q <= (cmd == CMD_ARRIVE) ? S_SCAN : S_ACT_RD;
					end
				end
				S_SCAN: begin
					v_s1   <= seg_re;
					idx_s1 <= i_q[IDX_W-1:0];
					if (seg_re) begin
						i_q <= i_q + 1'b1;
					end
					if (v_s1 && fits && better) begin
						have_q <= 1'b1;
						pick_q <= idx_s1;
						best_q <= diff;
					end
					if (scan_done) begin
						if (have_q) begin
							state_q <= S_PLACE;
						end else if (retry_q) begin
							state_q <= S_IDLE;
						end else begin
							status_q <= (pcnt < PC_W'(PENDING_DEPTH)) ? ST_QUEUED
								: ST_DROP_PEND;
							state_q  <= S_ACT_RD;
						end
					end
				end
				S_PLACE: begin
					if (best_q == '0) begin
						state_q <= S_WR_OWN;
					end else if (cnt_q == CNT_W'(MAX_SEGMENTS)) begin
						status_q <= ST_DROP_TABLE;
						state_q  <= retry_q ? S_IDLE : S_ACT_RD;
					end else if (cnt_q > CNT_W'(pick_q) + CNT_W'(1)) begin
						j_q     <= cnt_m1[IDX_W-1:0];
						state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_WR_HOLE;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if ({1'b0, j_q} > {1'b0, pick_q} + 1'b1) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_WR_HOLE;
					end
				end
				S_WR_HOLE: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_WR_OWN;
				end
				S_WR_OWN: begin
					status_q <= ST_PLACED;
					state_q  <= retry_q ? S_RETRY : S_ACT_RD;
				end
				S_ACT_RD: begin
					state_q <= S_ACT_CHK;
				end
				S_ACT_CHK: begin
					act_q   <= act_now;
					i_q     <= '0;
					w_q     <= '0;
					acc_v_q <= 1'b0;
					start_q <= '0;
					state_q <= (end_q == CMD_END) ? S_MAP_RD : S_ARR_OUT;
				end
				S_ARR_OUT: begin
					if (out_free) begin
						kind_q      <= KIND_STATUS;
						rstat_q     <= status_q;
						rinst_q     <= inst_q;
						rstart_q    <= '0;
						rsize_q     <= '0;
						rhole_q     <= 1'b0;
						rowner_q    <= '0;
						ract_q      <= act_q;
						rlast_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_MAP_RD: begin
					state_q <= S_MAP_EMIT;
				end
				S_MAP_EMIT: begin
					if (out_free) begin
						kind_q      <= KIND_MAP;
						rstat_q     <= ST_PLACED;
						rinst_q     <= inst_q;
						rstart_q    <= start_q;
						rsize_q     <= seg_rdata.size;
						rhole_q     <= seg_rdata.free;
						rowner_q    <= seg_rdata.free ? '0 : seg_rdata.owner;
						ract_q      <= act_q;
						rlast_q     <= (i_q + 1'b1) == cnt_q;
						start_q     <= start_q + seg_rdata.size;
						if (merge_now) begin
							acc_q.size <= msize;
						end else begin
							if (acc_v_q) begin
								w_q <= w_q + 1'b1;
							end
							acc_q   <= dec;
							acc_v_q <= 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= ((i_q + 1'b1) == cnt_q) ? S_MAP_END : S_MAP_RD;
					end
				end
				S_MAP_END: begin
					cnt_q   <= CNT_W'(w_q) + CNT_W'(1);
					inst_q  <= inst_q + 1'b1;
					state_q <= S_RETRY;
				end
				S_RETRY: begin
					state_q <= (pcnt == '0) ? S_IDLE : S_RETRY_HD;
				end
				S_RETRY_HD: begin
					if (pend_rdata.size > total_q) begin
						state_q <= S_RETRY;
					end else begin
						id_q    <= pend_rdata.id;
						size_q  <= pend_rdata.size;
						run_q   <= pend_rdata.run;
						retry_q <= 1'b1;
						i_q     <= '0;
						v_s1    <= 1'b0;
						have_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall    = state_q != S_IDLE;
	assign rsp_valid    = rsp_valid_q;
	assign kind         = kind_q;
	assign status       = rstat_q;
	assign instant      = rinst_q;
	assign seg_start    = rstart_q;
	assign seg_size     = rsize_q;
	assign seg_is_hole  = rhole_q;
	assign seg_owner    = rowner_q;
	assign still_active = ract_q;
	assign last         = rlast_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count out of range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(seg_we && seg_re && seg_waddr == seg_raddr))
		else $error("table read and write hit the same entry");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_TOTAL |=> cnt_q == CNT_W'(1) && pcnt == '0)
		else $error("restart left segments or queued requests");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt <= PC_W'(PENDING_DEPTH))
		else $error("pending queue overflow");

endmodule
`default_nettype wire

@@ tb/alloc_map_monitor.sv @@
`default_nettype none
module alloc_map_monitor
	import vpfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	input  wire logic                 req_stall,
	input  wire logic                 cmd,
	input  wire logic [ID_W-1:0]      proc_id,
	input  wire logic [SZ_W-1:0]      proc_size,
	input  wire logic [RUN_W-1:0]     run_time,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire logic                 kind,
	input  wire logic [1:0]           status,
	input  wire logic [INST_W-1:0]    instant,
	input  wire logic [SZ_W-1:0]      seg_start,
	input  wire logic [SZ_W-1:0]      seg_size,
	input  wire logic                 seg_is_hole,
	input  wire logic [ID_W-1:0]      seg_owner,
	input  wire logic                 still_active,
	input  wire logic                 last,
	output int                        fail_count,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEG = DEF_MAX_SEGMENTS;
	localparam int NPEND = DEF_PENDING_DEPTH;

	typedef struct {
		logic              kind;
		logic [1:0]        status;
		logic [INST_W-1:0] instant;
		logic [SZ_W-1:0]   start;
		logic [SZ_W-1:0]   size;
		logic              hole;
		logic [ID_W-1:0]   owner;
		logic              act;
		logic              last;
	} alloc_result_t;

	alloc_result_t alloc_results[$];

	logic [SZ_W-1:0]  mem_total;
	logic             fit_worst;
	logic [ID_W-1:0]  map_owner[NSEG];
	int unsigned      map_size[NSEG];
	int unsigned      map_left[NSEG];
	bit               map_free[NSEG];
	int               map_cnt;
	logic [ID_W-1:0]  wait_id[NPEND];
	int unsigned      wait_size[NPEND];
	int unsigned      wait_run[NPEND];
	int               wait_cnt;
	logic [INST_W-1:0] now;

	function automatic void clear_map();
		for (int i = 0; i < NSEG; i++) begin
			map_owner[i] = '0;
			map_size[i] = 0;
			map_left[i] = 0;
			map_free[i] = 1'b0;
		end
		map_size[0] = 32'(mem_total);
		map_free[0] = 1'b1;
		map_cnt = 1;
		wait_cnt = 0;
		now = INST_W'(1);
	endfunction

	function automatic void move_seg(int dst, int src);
		map_owner[dst] = map_owner[src];
		map_size[dst] = map_size[src];
		map_left[dst] = map_left[src];
		map_free[dst] = map_free[src];
	endfunction

	function automatic void merge_holes();
		int i;
		int unsigned s;
		i = map_cnt;
		while (i > 1) begin
			i--;
			if (map_free[i-1] && map_free[i]) begin
				s = map_size[i-1] + map_size[i];
				map_size[i-1] = (s > 65535) ? 65535 : s;
				for (int j = i; j < map_cnt - 1; j++)
					move_seg(j, j + 1);
				map_cnt--;
			end
		end
	endfunction

	function automatic bit place_seg(int idx, logic [ID_W-1:0] id, int unsigned sz,
			int unsigned rt);
		int unsigned rest;
		rest = map_size[idx] - sz;
		if (rest != 0) begin
			if (map_cnt >= NSEG)
				return 1'b0;
			for (int j = map_cnt; j > idx + 1; j--)
				move_seg(j, j - 1);
			map_owner[idx+1] = '0;
			map_size[idx+1] = rest;
			map_left[idx+1] = 0;
			map_free[idx+1] = 1'b1;
			map_cnt++;
		end
		map_owner[idx] = id;
		map_size[idx] = sz;
		map_left[idx] = rt;
		map_free[idx] = 1'b0;
		merge_holes();
		return 1'b1;
	endfunction

	function automatic logic busy();
		bit any;
		any = 1'b0;
		if (wait_cnt != 0)
			return 1'b1;
		for (int i = 0; i < map_cnt; i++)
			if (!map_free[i])
				any = 1'b1;
		if (map_free[0] && map_size[0] == 32'(mem_total))
			any = 1'b0;
		return any;
	endfunction

	function automatic void pop_waiting();
		for (int j = 0; j < wait_cnt - 1; j++) begin
			wait_id[j] = wait_id[j+1];
			wait_size[j] = wait_size[j+1];
			wait_run[j] = wait_run[j+1];
		end
		wait_cnt--;
	endfunction

	function automatic void retry_waiting();
		int i;
		bit found;
		while (wait_cnt != 0) begin
			if (wait_size[0] > 32'(mem_total)) begin
				pop_waiting();
				continue;
			end
			found = 1'b0;
			for (i = 0; i < map_cnt; i++)
				if (map_free[i] && wait_size[0] <= map_size[i]) begin
					found = 1'b1;
					break;
				end
			if (!found)
				return;
			if (!place_seg(i, wait_id[0], wait_size[0], wait_run[0]))
				return;
			pop_waiting();
		end
	endfunction

	function automatic void predict_alloc(logic c, logic [ID_W-1:0] id, int unsigned sz,
			int unsigned rt);
		alloc_result_t r;
		int pick;
		int unsigned best, d, start;
		logic act;
		if (c == CMD_ARRIVE) begin
			pick = -1;
			best = 0;
			if (rt == 0)
				rt = 1;
			for (int i = 0; i < map_cnt; i++)
				if (map_free[i] && sz <= map_size[i]) begin
					d = map_size[i] - sz;
					if (pick < 0 || (fit_worst ? d > best : d < best)) begin
						pick = i;
						best = d;
					end
				end
			if (pick >= 0)
				r.status = place_seg(pick, id, sz, rt) ? ST_PLACED : ST_DROP_TABLE;
			else if (wait_cnt >= NPEND)
				r.status = ST_DROP_PEND;
			else begin
				wait_id[wait_cnt] = id;
				wait_size[wait_cnt] = sz;
				wait_run[wait_cnt] = rt;
				wait_cnt++;
				r.status = ST_QUEUED;
			end
			r.kind = KIND_STATUS;
			r.instant = now;
			r.start = '0;
			r.size = '0;
			r.hole = 1'b0;
			r.owner = '0;
			r.act = busy();
			r.last = 1'b1;
			alloc_results.insert(alloc_results.size(), r);
		end else begin
			act = busy();
			start = 0;
			for (int i = 0; i < map_cnt; i++) begin
				r.kind = KIND_MAP;
				r.status = ST_PLACED;
				r.instant = now;
				r.start = start[SZ_W-1:0];
				r.size = map_size[i][SZ_W-1:0];
				r.hole = map_free[i];
				r.owner = map_free[i] ? '0 : map_owner[i];
				r.act = act;
				r.last = (i == map_cnt - 1);
				alloc_results.insert(alloc_results.size(), r);
				start += map_size[i];
			end
			for (int i = 0; i < map_cnt; i++)
				if (!map_free[i]) begin
					if (map_left[i] != 0)
						map_left[i]--;
					if (map_left[i] == 0) begin
						map_free[i] = 1'b1;
						map_owner[i] = '0;
					end
				end
			merge_holes();
			now = now + 1'b1;
			retry_waiting();
		end
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			mem_total = TOTAL_RST;
			fit_worst = 1'b0;
			clear_map();
			alloc_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TOTAL) begin
					mem_total = cfg_data;
					clear_map();
				end else if (cfg_index == REG_FIT)
					fit_worst = cfg_data[0];
			end
			if (rsp_valid && !rsp_stall) begin
				if (alloc_results.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					e = alloc_results.pop_front();
					check_field("kind", 32'(e.kind), 32'(kind));
					check_field("status", 32'(e.status), 32'(status));
					check_field("instant", 32'(e.instant), 32'(instant));
					check_field("seg_start", 32'(e.start), 32'(seg_start));
					check_field("seg_size", 32'(e.size), 32'(seg_size));
					check_field("seg_is_hole", 32'(e.hole), 32'(seg_is_hole));
					check_field("seg_owner", 32'(e.owner), 32'(seg_owner));
					check_field("still_active", 32'(e.act), 32'(still_active));
					check_field("last", 32'(e.last), 32'(last));
				end
			end
			if (req_valid && !req_stall)
				predict_alloc(cmd, proc_id, 32'(proc_size), 32'(run_time));
		end
		outstanding = alloc_results.size();
	end
endmodule
`default_nettype wire

@@ tb/variable_partition_fit_allocator_unit_test.sv @@
`default_nettype none
module variable_partition_fit_allocator_unit_test;
	import vpfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic                 cmd = 1'b0;
	logic [ID_W-1:0]      proc_id = '0;
	logic [SZ_W-1:0]      proc_size = '0;
	logic [RUN_W-1:0]     run_time = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 kind;
	logic [1:0]           status;
	logic [INST_W-1:0]    instant;
	logic [SZ_W-1:0]      seg_start;
	logic [SZ_W-1:0]      seg_size;
	logic                 seg_is_hole;
	logic [ID_W-1:0]      seg_owner;
	logic                 still_active;
	logic                 last;
	int                   fail_count;
	int                   outstanding;

	int unsigned tx_idle = 12;
	int unsigned rx_idle = 59;
	logic        hold_rx = 1'b0;
	bit          hold_go = 1'b0;
	int unsigned mem_total = 1024;
	int unsigned size_cap = 170;

	variable_partition_fit_allocator_unit dut (.*);

	alloc_map_monitor mon (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		rsp_stall <= hold_rx || ($urandom_range(99) < rx_idle);

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (600) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#20ms;
		$display("variable_partition_fit_allocator_unit_test: errors");
		$finish;
	end

	task automatic send_item(logic c, logic [ID_W-1:0] id, logic [SZ_W-1:0] sz,
			logic [RUN_W-1:0] rt);
		if ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		proc_id <= id;
		proc_size <= sz;
		run_time <= rt;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic send_random();
		int unsigned r, sz, rt;
		r = $urandom_range(99);
		if (r < 70)
			sz = $urandom_range(0, size_cap);
		else if (r < 85)
			sz = $urandom_range(0, mem_total);
		else if (r < 93)
			sz = $urandom_range(0, 65535);
		else
			sz = mem_total;
		r = $urandom_range(99);
		if (r < 80)
			rt = $urandom_range(0, 4);
		else if (r < 95)
			rt = $urandom_range(5, 20);
		else
			rt = $urandom_range(0, 65535);
		send_item(($urandom_range(99) < 28) ? CMD_END : CMD_ARRIVE,
			ID_W'($urandom_range(255)), SZ_W'(sz), RUN_W'(rt));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || req_stall) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int unsigned total, logic fit, int unsigned cap, int n);
		drain();
		write_reg(REG_TOTAL, CFG_W'(total));
		write_reg(REG_FIT, CFG_W'(fit));
		mem_total = total;
		size_cap = cap;
		repeat (n) send_random();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero run time, exact fit, oversized, queueing and retry
		send_item(CMD_ARRIVE, 8'hFF, 16'd0, 16'd0);
		send_item(CMD_ARRIVE, 8'd1, 16'd100, 16'd1);
		send_item(CMD_ARRIVE, 8'd2, 16'd300, 16'd2);
		send_item(CMD_ARRIVE, 8'd0, 16'd1024, 16'hFFFF);
		send_item(CMD_ARRIVE, 8'hAA, 16'hFFFF, 16'd3);
		send_item(CMD_ARRIVE, 8'h55, 16'd624, 16'd1);
		send_item(CMD_END, 8'd0, 16'd0, 16'd0);
		send_item(CMD_END, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_item(CMD_END, 8'd0, 16'd0, 16'd1);
		send_item(CMD_ARRIVE, 8'd3, 16'd1, 16'd1);
		send_item(CMD_END, 8'd0, 16'd0, 16'd0);
		repeat (50) send_random();

		run_phase(1024, 1'b1, 40, 50);
		hold_go = 1'b1;
		repeat (20) send_random();

		tx_idle = 59;
		rx_idle = 12;
		run_phase(16, 1'b0, 16, 50);
		run_phase(0, 1'b1, 0, 30);

		tx_idle = 0;
		rx_idle = 0;
		run_phase(65535, 1'b0, 10922, 50);
		run_phase(200, 1'b1, 30, 50);

		drain();
		if (fail_count == 0)
			$display("variable_partition_fit_allocator_unit_test: clean");
		else
			$display("variable_partition_fit_allocator_unit_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
design/vpfa_pkg.sv
design/vpfa_seg_mem.sv
design/vpfa_pend_fifo.sv
design/variable_partition_fit_allocator_unit.sv
tb/alloc_map_monitor.sv
tb/variable_partition_fit_allocator_unit_test.sv
